// ===== rtl/core/drs_pkg.sv =====
// Shared types, codes and helpers of the decimating RGB565 scaler.
`timescale 1ns / 1ps

package drs_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD_PERIOD = 3'd4;

   // Divisions run at frame start, in this order
   localparam logic [1:0] DIV_W_BOUND  = 2'd0;  // width / max_width
   localparam logic [1:0] DIV_H_BOUND  = 2'd1;  // height / max_height
   localparam logic [1:0] DIV_W_SCALED = 2'd2;  // width / scale
   localparam logic [1:0] DIV_H_SCALED = 2'd3;  // height / scale

   localparam logic [7:0] RB_MASK    = 8'hF8;
   localparam logic [7:0] GREEN_MASK = 8'hFC;

   typedef struct packed {
      logic       div_start;
      logic       div_capture;
      logic [1:0] div_idx;
      logic       load_pixel;
      logic       exec;
   } cmd_type;

   typedef struct packed {
      logic frame_start;
      logic div_done;
      logic out_busy;
   } status_type;

   function automatic logic [15:0] rgb565(input logic [7:0] red, input logic [7:0] green,
                                          input logic [7:0] blue);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = red & RB_MASK;
      g = green & GREEN_MASK;
      b = blue & RB_MASK;
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

// ===== rtl/core/drs_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module drs_divider #(
   parameter int DIM_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIM_BITS-1:0] dividend,
   input  logic [DIM_BITS-1:0] divisor,
   output logic                done,
   output logic [DIM_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIM_BITS + 1);

   logic [DIM_BITS-1:0] rem_ff, rem_in;
   logic [DIM_BITS-1:0] quo_ff, quo_in;
   logic [DIM_BITS-1:0] div_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIM_BITS:0]   trial;
   logic [DIM_BITS:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIM_BITS-1]};
      diff    = trial - {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_BITS'(DIM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIM_BITS-1:0];
            quo_in = {quo_ff[DIM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DIM_BITS-1:0];
            quo_in = {quo_ff[DIM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start && !busy_ff) begin
         div_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/drs_datapath.sv =====
// Scaler datapath: settings, frame geometry, position counters and output stage.
`timescale 1ns / 1ps

module drs_datapath #(
   parameter int DIM_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  drs_pkg::cmd_type                     cmd,
   output drs_pkg::status_type                  status,
   input  logic [23:0]                          req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [drs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [DIM_BITS-1:0]                  csr_wdata
);

   localparam logic [DIM_BITS-1:0] ONE = DIM_BITS'(1);

   // Settings
   logic [DIM_BITS-1:0] src_width_ff, src_height_ff;
   logic [7:0]          max_width_ff, max_height_ff;
   logic [6:0]          pad_period_ff;

   // Frame geometry
   logic [DIM_BITS-1:0] bound_w_ff;
   logic [DIM_BITS-1:0] scale_ff, scale_in;
   logic [7:0]          scaled_w_ff, scaled_h_ff;

   // Position
   logic [DIM_BITS-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [DIM_BITS-1:0] col_ph_ff, col_ph_in, row_ph_ff, row_ph_in;
   logic [7:0]          out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [6:0]          pad_cnt_ff, pad_cnt_in;

   logic [15:0]         pix_ff;
   logic                out_valid_ff, pad_pend_ff, pad_last_ff, out_last_ff;
   logic [15:0]         out_pixel_ff;

   logic [DIM_BITS-1:0] w_eff, h_eff, mw_eff, mh_eff;
   logic [DIM_BITS-1:0] div_dividend, div_divisor, div_quotient;
   logic                div_done;
   logic [DIM_BITS-1:0] bound_max;
   logic [DIM_BITS:0]   scale_full;
   logic                frame_start;

   // Step terms
   logic [DIM_BITS-1:0] cp, rp;
   logic [7:0]          oc, orow;
   logic [6:0]          pc, pc_inc;
   logic                emit, row_end, final_row, pad;
   logic [DIM_BITS:0]   cp_inc, rp_inc;
   logic [DIM_BITS-1:0] sc_inc, sr_inc;

   assign w_eff  = (src_width_ff == '0) ? ONE : src_width_ff;
   assign h_eff  = (src_height_ff == '0) ? ONE : src_height_ff;
   assign mw_eff = (max_width_ff == 8'd0) ? ONE : DIM_BITS'(max_width_ff);
   assign mh_eff = (max_height_ff == 8'd0) ? ONE : DIM_BITS'(max_height_ff);

   assign frame_start = (src_row_ff == '0) && (src_col_ff == '0);

   always_comb begin
      case (cmd.div_idx)
         drs_pkg::DIV_W_BOUND: begin
            div_dividend = w_eff;
            div_divisor  = mw_eff;
         end
         drs_pkg::DIV_H_BOUND: begin
            div_dividend = h_eff;
            div_divisor  = mh_eff;
         end
         drs_pkg::DIV_W_SCALED: begin
            div_dividend = w_eff;
            div_divisor  = scale_ff;
         end
         default: begin
            div_dividend = h_eff;
            div_divisor  = scale_ff;
         end
      endcase
   end

   drs_divider #(.DIM_BITS(DIM_BITS)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // scale = max(bounds) + 1, saturating
   always_comb begin
      bound_max  = (bound_w_ff > div_quotient) ? bound_w_ff : div_quotient;
      scale_full = {1'b0, bound_max} + {{DIM_BITS{1'b0}}, 1'b1};
      scale_in   = scale_full[DIM_BITS] ? {DIM_BITS{1'b1}} : scale_full[DIM_BITS-1:0];
   end

   // One step of the frame walk
   always_comb begin
      cp   = frame_start ? '0 : col_ph_ff;
      rp   = frame_start ? '0 : row_ph_ff;
      oc   = frame_start ? 8'd0 : out_col_ff;
      orow = frame_start ? 8'd0 : out_row_ff;
      pc   = frame_start ? 7'd0 : pad_cnt_ff;

      emit      = (rp == '0) && (cp == '0) && (orow < scaled_h_ff) && (oc < scaled_w_ff);
      row_end   = ({1'b0, oc} + 9'd1) == {1'b0, scaled_w_ff};
      final_row = ({1'b0, orow} + 9'd1) == {1'b0, scaled_h_ff};

      pad_cnt_in = pc;
      pad        = 1'b0;
      pc_inc     = pc + 7'd1;
      if (emit && row_end && (pad_period_ff != 7'd0)) begin
         if (pc_inc >= pad_period_ff) begin
            pad_cnt_in = 7'd0;
            pad        = 1'b1;
         end else begin
            pad_cnt_in = pc_inc;
         end
      end

      out_col_in = emit ? (oc + 8'd1) : oc;
      out_row_in = orow;

      cp_inc    = {1'b0, cp} + {{DIM_BITS{1'b0}}, 1'b1};
      col_ph_in = (cp_inc >= {1'b0, scale_ff}) ? '0 : cp_inc[DIM_BITS-1:0];
      row_ph_in = rp;
      rp_inc    = {1'b0, rp} + {{DIM_BITS{1'b0}}, 1'b1};

      sc_inc     = src_col_ff + ONE;
      src_col_in = sc_inc;
      src_row_in = src_row_ff;
      sr_inc     = src_row_ff + ONE;
      if ((sc_inc >= w_eff) || (sc_inc == '0)) begin
         src_col_in = '0;
         col_ph_in  = '0;
         out_col_in = 8'd0;
         if ((rp == '0) && (orow < scaled_h_ff)) begin
            out_row_in = orow + 8'd1;
         end
         row_ph_in  = (rp_inc >= {1'b0, scale_ff}) ? '0 : rp_inc[DIM_BITS-1:0];
         src_row_in = (sr_inc >= h_eff) ? '0 : sr_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_BITS'(128);
         src_height_ff <= DIM_BITS'(128);
         max_width_ff  <= 8'd114;
         max_height_ff <= 8'd85;
         pad_period_ff <= 7'd0;
      end else if (csr_we) begin
         case (csr_index)
            drs_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            drs_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            drs_pkg::CSR_MAX_WIDTH:  max_width_ff  <= csr_wdata[7:0];
            drs_pkg::CSR_MAX_HEIGHT: max_height_ff <= csr_wdata[7:0];
            drs_pkg::CSR_PAD_PERIOD: pad_period_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_w_ff  <= '0;
         scale_ff    <= '0;
         scaled_w_ff <= 8'd0;
         scaled_h_ff <= 8'd0;
      end else if (cmd.div_capture) begin
         case (cmd.div_idx)
            drs_pkg::DIV_W_BOUND:  bound_w_ff  <= div_quotient;
            drs_pkg::DIV_H_BOUND:  scale_ff    <= scale_in;
            drs_pkg::DIV_W_SCALED: scaled_w_ff <= div_quotient[7:0];
            default:               scaled_h_ff <= div_quotient[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         col_ph_ff  <= '0;
         row_ph_ff  <= '0;
         out_col_ff <= 8'd0;
         out_row_ff <= 8'd0;
         pad_cnt_ff <= 7'd0;
      end else if (cmd.exec) begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         col_ph_ff  <= col_ph_in;
         row_ph_ff  <= row_ph_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pad_cnt_ff <= pad_cnt_in;
      end
   end

   // Output stage: the kept pixel, then its pad repeat if any
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pad_pend_ff  <= 1'b0;
      end else if (cmd.exec) begin
         out_valid_ff <= emit;
         pad_pend_ff  <= emit && pad;
      end else if (out_valid_ff && rsp_tready) begin
         if (pad_pend_ff) begin
            pad_pend_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         pix_ff <= drs_pkg::rgb565(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
      end
      if (cmd.exec) begin
         out_pixel_ff <= pix_ff;
         out_last_ff  <= row_end && final_row && !pad;
         pad_last_ff  <= row_end && final_row;
      end else if (out_valid_ff && rsp_tready && pad_pend_ff) begin
         out_last_ff <= pad_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tlast  = out_last_ff;

   assign status.frame_start = frame_start;
   assign status.div_done    = div_done;
   assign status.out_busy    = out_valid_ff;

endmodule

// ===== rtl/core/drs_controller.sv =====
// Scaler controller: accept, frame-start divisions, step execution.
`timescale 1ns / 1ps

module drs_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  drs_pkg::status_type status,
   output drs_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_DIV_GO   = 2'd1;
   localparam logic [1:0] ST_DIV_WAIT = 2'd2;
   localparam logic [1:0] ST_EXEC     = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      req_tready      = 1'b0;
      cmd.div_start   = 1'b0;
      cmd.div_capture = 1'b0;
      cmd.div_idx     = idx_ff;
      cmd.load_pixel  = 1'b0;
      cmd.exec        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_pixel = 1'b1;
               idx_in         = drs_pkg::DIV_W_BOUND;
               state_in       = status.frame_start ? ST_DIV_GO : ST_EXEC;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               if (idx_ff == drs_pkg::DIV_H_SCALED) begin
                  state_in = ST_EXEC;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_EXEC: begin
            if (!status.out_busy) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= drs_pkg::DIV_W_BOUND;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/core/decimating_rgb565_scaler.sv =====
// Top level of the nearest-neighbor RGB888 to RGB565 decimating scaler.
// Each source pixel is accepted, then stepped, before another is taken; the step waits while the output is busy.
// Frame start adds four serial divisions on one shared divider.
// rsp_tvalid is registered: for a kept pixel it rises with the step that follows the accept, after any divisions.
// Reset (synchronous, active high) loads the default settings and zeroes the geometry,
// the position counters and the output-stage valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module decimating_rgb565_scaler #(
   parameter int DIM_BITS = 12   // source dimension width, 8..16
) (
   input  logic                               clock,
   input  logic                               reset,
   // source pixel stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [23:0]                        req_tdata,   // red[7:0], green[15:8], blue[23:16]
   // scaled RGB565 stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // pixel[15:0]
   output logic                               rsp_tlast,   // final pixel of the scaled image
   // settings write port
   input  logic                               csr_we,
   input  logic [drs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]                csr_wdata
);

   // Controller sequences each transaction; datapath holds the settings, divider, counters and output stage.
   drs_pkg::cmd_type    cmd;
   drs_pkg::status_type status;

   drs_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: divider for scale/scaled sizes, frame walk counters, two-result output stage
   drs_datapath #(.DIM_BITS(DIM_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule
